/* hw/rtl/tru_pkg.sv */
// shared types and constants for the triangular rank-one update core
package tru_pkg;

	// item kinds on the input channel
	typedef enum logic [1:0] {
		KIND_LOAD_X = 2'd0,
		KIND_LOAD_Y = 2'd1,
		KIND_MATRIX = 2'd2
	} kind_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHA_RE       = 3'd0,
		CFG_ALPHA_IM       = 3'd1,
		CFG_LOWER_TRIANGLE = 3'd2,
		CFG_CONJUGATE_MODE = 3'd3,
		CFG_ROW_COUNT      = 3'd4,
		CFG_COL_COUNT      = 3'd5
	} cfg_reg_t;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// mode bits shared by front and back
	typedef struct packed {
		logic lower_triangle;
		logic conjugate_mode;
	} mode_t;

	// per-element flags worked out by the front
	typedef struct packed {
		logic in_tri;
		logic zero_im;
		logic last;
	} tag_t;

	localparam int TAG_W = $bits(tag_t);

endpackage

/* hw/rtl/triangular_rank1_update_core.sv */
// top level of the triangular rank-one update core
//
// usage
// - input channel (push/full): a beat carries kind, index and a complex value.
//   kind load x or load y writes the value into the x or y store at index and
//   gives no result; kind matrix streams one element of A in column-major
//   order and gives exactly one result; the unused kind is dropped
// - result channel (empty/pop): one beat per matrix element, in input order,
//   with last_element set on the element that closes the matrix
// - configuration: cfg_write with cfg_index and cfg_data, only while idle
// - a matrix beat passes the store read, the queue, three arithmetic stages and
//   the result register on its way to the result ports
// - throughput: one beat per cycle while full is low, loads and matrix elements alike; the
//   x and y stores each take one write and one read per cycle
// - a stalled result holds the back pipeline; the four-entry queue keeps the
//   front taking beats until it and the store read stage hold four, then full rises
// - reset clears the position counters, all pipeline valids and the queue,
//   and loads the register defaults; the stores hold garbage until loaded
module triangular_rank1_update_core #(
	parameter int MAX_DIM    = 64,
	parameter int DATA_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  push,
	output logic                                  full,
	input  logic [1:0]                            kind,
	input  logic [$clog2(MAX_DIM)-1:0]            index,
	input  logic signed [DATA_WIDTH-1:0]          value_re,
	input  logic signed [DATA_WIDTH-1:0]          value_im,
	// result channel
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [DATA_WIDTH-1:0]          result_re,
	output logic signed [DATA_WIDTH-1:0]          result_im,
	output logic                                  last_element,
	// configuration
	input  logic                                  cfg_write,
	input  logic [tru_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [((DATA_WIDTH > $clog2(MAX_DIM+1)) ?
	               DATA_WIDTH : $clog2(MAX_DIM+1))-1:0] cfg_data
);

	localparam int DW      = DATA_WIDTH;
	localparam int IDX_W   = $clog2(MAX_DIM);
	localparam int CNT_W   = $clog2(MAX_DIM + 1);
	localparam int ENTRY_W = 6 * DW + tru_pkg::TAG_W;
	localparam int QDEPTH  = tru_pkg::QUEUE_DEPTH;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// alpha resets to one in the fixed-point format (four integer bits)
	localparam logic [DW-1:0] ALPHA_ONE = {3'b000, 1'b1, {(DW-4){1'b0}}};

	logic signed [DW-1:0] alpha_re_q, alpha_im_q;
	tru_pkg::mode_t       mode_q;
	logic [CNT_W-1:0]     row_count_q, col_count_q;

	logic               accept;
	logic               front_valid_s1;
	logic [ENTRY_W-1:0] front_entry_s1;
	logic [ENTRY_W-1:0] q_entry;
	logic               q_not_empty, q_pop;
	logic [QCNT_W-1:0]  q_count;
	logic               out_valid;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_re_q            <= ALPHA_ONE;
			alpha_im_q            <= '0;
			mode_q.lower_triangle <= 1'b1;
			mode_q.conjugate_mode <= 1'b0;
			row_count_q           <= CNT_W'(MAX_DIM);
			col_count_q           <= CNT_W'(MAX_DIM);
		end else if (cfg_write) begin
			unique case (cfg_index)
				tru_pkg::CFG_ALPHA_RE:       alpha_re_q            <= cfg_data[DW-1:0];
				tru_pkg::CFG_ALPHA_IM:       alpha_im_q            <= cfg_data[DW-1:0];
				tru_pkg::CFG_LOWER_TRIANGLE: mode_q.lower_triangle <= cfg_data[0];
				tru_pkg::CFG_CONJUGATE_MODE: mode_q.conjugate_mode <= cfg_data[0];
				tru_pkg::CFG_ROW_COUNT:      row_count_q           <= cfg_data[CNT_W-1:0];
				tru_pkg::CFG_COL_COUNT:      col_count_q           <= cfg_data[CNT_W-1:0];
				default: begin
					// writes to unused indexes are dropped
				end
			endcase
		end
	end

	// leave room for the element still in the store read stage
	assign full   = ({1'b0, q_count} + (QCNT_W+1)'(front_valid_s1)) >= (QCNT_W+1)'(QDEPTH);
	assign accept = push && !full;

	tru_front #(
		.MAX_DIM    (MAX_DIM),
		.DATA_WIDTH (DW),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W),
		.ENTRY_W    (ENTRY_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (kind),
		.index     (index),
		.value_re  (value_re),
		.value_im  (value_im),
		.mode      (mode_q),
		.row_count (row_count_q),
		.col_count (col_count_q),
		.valid_s1  (front_valid_s1),
		.entry_s1  (front_entry_s1)
	);

	tru_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QDEPTH),
		.CNT_W (QCNT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (front_valid_s1),
		.wr_data   (front_entry_s1),
		.rd_en     (q_pop),
		.rd_data   (q_entry),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	tru_back #(
		.DATA_WIDTH (DW),
		.ENTRY_W    (ENTRY_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_not_empty),
		.q_entry      (q_entry),
		.q_pop        (q_pop),
		.alpha_re     (alpha_re_q),
		.alpha_im     (alpha_im_q),
		.mode         (mode_q),
		.out_valid    (out_valid),
		.out_pop      (pop),
		.result_re    (result_re),
		.result_im    (result_im),
		.last_element (last_element)
	);

	assign empty = !out_valid;

endmodule

/* hw/rtl/tru_front.sv */
// front end: vector stores, position counters and element classification
module tru_front #(
	parameter int MAX_DIM    = 64,
	parameter int DATA_WIDTH = 16,
	parameter int IDX_W      = 6,
	parameter int CNT_W      = 7,
	parameter int ENTRY_W    = 99
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [1:0]                   kind,
	input  logic [IDX_W-1:0]             index,
	input  logic signed [DATA_WIDTH-1:0] value_re,
	input  logic signed [DATA_WIDTH-1:0] value_im,
	input  tru_pkg::mode_t               mode,
	input  logic [CNT_W-1:0]             row_count,
	input  logic [CNT_W-1:0]             col_count,
	output logic                         valid_s1,
	output logic [ENTRY_W-1:0]           entry_s1
);

	localparam int DW  = DATA_WIDTH;
	localparam int EW  = 2 * DW;

	logic [EW-1:0] x_mem [MAX_DIM];
	logic [EW-1:0] y_mem [MAX_DIM];

	logic [IDX_W-1:0] row_q, col_q;
	logic [CNT_W-1:0] m_eff, n_eff;
	logic [CNT_W-1:0] row_nxt, col_nxt;
	logic             row_wrap, col_wrap;
	logic             idx_ok, is_x, is_y, is_mat;
	tru_pkg::tag_t    tag;

	logic [EW-1:0]         x_rd_s1, y_rd_s1;
	logic signed [DW-1:0]  v_re_s1, v_im_s1;
	tru_pkg::tag_t         tag_s1;

	assign is_x   = kind == tru_pkg::KIND_LOAD_X;
	assign is_y   = kind == tru_pkg::KIND_LOAD_Y;
	assign is_mat = kind == tru_pkg::KIND_MATRIX;
	assign idx_ok = {1'b0, index} < (IDX_W+1)'(MAX_DIM);

	// counts of zero act as one, counts beyond the store depth are clamped
	always_comb begin
		priority if (row_count == '0) begin
			m_eff = CNT_W'(1);
		end else if (row_count > CNT_W'(MAX_DIM)) begin
			m_eff = CNT_W'(MAX_DIM);
		end else begin
			m_eff = row_count;
		end
		priority if (col_count == '0) begin
			n_eff = CNT_W'(1);
		end else if (col_count > CNT_W'(MAX_DIM)) begin
			n_eff = CNT_W'(MAX_DIM);
		end else begin
			n_eff = col_count;
		end
	end

	assign row_nxt  = CNT_W'(row_q) + CNT_W'(1);
	assign col_nxt  = CNT_W'(col_q) + CNT_W'(1);
	assign row_wrap = row_nxt >= m_eff;
	assign col_wrap = col_nxt >= n_eff;

	assign tag.in_tri  = mode.lower_triangle ? (row_q >= col_q) : (row_q <= col_q);
	assign tag.zero_im = mode.conjugate_mode && (row_q == col_q);
	assign tag.last    = row_wrap && col_wrap;

	// column-major walk over the matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && is_mat;
			if (accept && is_mat) begin
				if (row_wrap) begin
					row_q <= '0;
					col_q <= col_wrap ? '0 : col_nxt[IDX_W-1:0];
				end else begin
					row_q <= row_nxt[IDX_W-1:0];
				end
			end
		end
	end

	// vector stores, one write and one registered read each
	always_ff @(posedge clk) begin
		if (accept && is_x && idx_ok) begin
			x_mem[index] <= {value_re, value_im};
		end
		if (accept && is_mat) begin
			x_rd_s1 <= x_mem[row_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_y && idx_ok) begin
			y_mem[index] <= {value_re, value_im};
		end
		if (accept && is_mat) begin
			y_rd_s1 <= y_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_mat) begin
			v_re_s1 <= value_re;
			v_im_s1 <= value_im;
			tag_s1  <= tag;
		end
	end

	assign entry_s1 = {v_re_s1, v_im_s1, x_rd_s1, y_rd_s1, tag_s1};

endmodule

/* hw/rtl/tru_queue.sv */
// small first-in first-out queue between front and back
module tru_queue #(
	parameter int WIDTH = 99,
	parameter int DEPTH = 4,
	parameter int CNT_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             not_empty,
	output logic [CNT_W-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slots [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data   = slots[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

endmodule

/* hw/rtl/tru_back.sv */
// back end: scaled y, complex multiply-accumulate, rounding and saturation
module tru_back #(
	parameter int DATA_WIDTH = 16,
	parameter int ENTRY_W    = 99
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  logic [ENTRY_W-1:0]           q_entry,
	output logic                         q_pop,
	input  logic signed [DATA_WIDTH-1:0] alpha_re,
	input  logic signed [DATA_WIDTH-1:0] alpha_im,
	input  tru_pkg::mode_t               mode,
	output logic                         out_valid,
	input  logic                         out_pop,
	output logic signed [DATA_WIDTH-1:0] result_re,
	output logic signed [DATA_WIDTH-1:0] result_im,
	output logic                         last_element
);

	localparam int DW     = DATA_WIDTH;
	localparam int FRAC   = DW - 4;
	localparam int PROD_W = 2 * DW;
	localparam int SUM_W  = 2 * DW + 2;
	localparam int TW     = tru_pkg::TAG_W;

	localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(1) << (FRAC - 1);
	localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

	function automatic logic signed [SUM_W-1:0] ext_p(input logic signed [PROD_W-1:0] p);
		ext_p = {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
	endfunction

	function automatic logic signed [SUM_W-1:0] ext_d(input logic signed [DW-1:0] d);
		ext_d = {{(SUM_W-DW){d[DW-1]}}, d};
	endfunction

	// round to nearest, ties towards plus infinity
	function automatic logic signed [SUM_W-1:0] rnd(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] t;
		t   = s + HALF;
		rnd = t >>> FRAC;
	endfunction

	function automatic logic signed [DW-1:0] sat(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] c;
		priority if (s > SAT_HI) begin
			c = SAT_HI;
		end else if (s < SAT_LO) begin
			c = SAT_LO;
		end else begin
			c = s;
		end
		sat = c[DW-1:0];
	endfunction

	logic adv;

	logic signed [DW-1:0] in_v_re, in_v_im, in_x_re, in_x_im, in_y_re, in_y_im;
	tru_pkg::tag_t        in_tag;

	// stage 1: alpha times y
	logic                     valid_s1;
	logic signed [PROD_W-1:0] ar_yr_s1, ai_yi_s1, ar_yi_s1, ai_yr_s1;
	logic signed [DW-1:0]     x_re_s1, x_im_s1, v_re_s1, v_im_s1;
	tru_pkg::tag_t            tag_s1;

	// stage 2: eta
	logic                     valid_s2;
	logic signed [DW-1:0]     eta_re_s2, eta_im_s2, x_re_s2, x_im_s2, v_re_s2, v_im_s2;
	tru_pkg::tag_t            tag_s2;
	logic signed [SUM_W-1:0]  eta_re_sum, eta_im_sum;

	// stage 3: x times eta
	logic                     valid_s3;
	logic signed [PROD_W-1:0] xr_er_s3, xi_ei_s3, xr_ei_s3, xi_er_s3;
	logic signed [DW-1:0]     v_re_s3, v_im_s3;
	tru_pkg::tag_t            tag_s3;

	logic signed [SUM_W-1:0]  upd_re, upd_im;
	logic signed [DW-1:0]     res_re, res_im;

	logic                     out_valid_q;
	logic signed [DW-1:0]     result_re_q, result_im_q;
	logic                     last_q;

	// whole pipeline holds while the result register is stalled
	assign adv   = !out_valid_q || out_pop;
	assign q_pop = adv && q_valid;

	assign in_tag  = tru_pkg::tag_t'(q_entry[TW-1:0]);
	assign in_y_im = q_entry[TW +: DW];
	assign in_y_re = q_entry[TW+DW +: DW];
	assign in_x_im = q_entry[TW+2*DW +: DW];
	assign in_x_re = q_entry[TW+3*DW +: DW];
	assign in_v_im = q_entry[TW+4*DW +: DW];
	assign in_v_re = q_entry[TW+5*DW +: DW];

	// conjugation flips the sign of every term that carries y_im
	assign eta_re_sum = mode.conjugate_mode ? ext_p(ar_yr_s1) + ext_p(ai_yi_s1)
	                                        : ext_p(ar_yr_s1) - ext_p(ai_yi_s1);
	assign eta_im_sum = mode.conjugate_mode ? ext_p(ai_yr_s1) - ext_p(ar_yi_s1)
	                                        : ext_p(ai_yr_s1) + ext_p(ar_yi_s1);

	assign upd_re = ext_d(v_re_s3) + rnd(ext_p(xr_er_s3) - ext_p(xi_ei_s3));
	assign upd_im = ext_d(v_im_s3) + rnd(ext_p(xr_ei_s3) + ext_p(xi_er_s3));

	always_comb begin
		res_re = v_re_s3;
		res_im = v_im_s3;
		if (tag_s3.in_tri) begin
			res_re = sat(upd_re);
			res_im = tag_s3.zero_im ? '0 : sat(upd_im);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= q_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ar_yr_s1    <= alpha_re * in_y_re;
			ai_yi_s1    <= alpha_im * in_y_im;
			ar_yi_s1    <= alpha_re * in_y_im;
			ai_yr_s1    <= alpha_im * in_y_re;
			x_re_s1     <= in_x_re;
			x_im_s1     <= in_x_im;
			v_re_s1     <= in_v_re;
			v_im_s1     <= in_v_im;
			tag_s1      <= in_tag;

			eta_re_s2   <= sat(rnd(eta_re_sum));
			eta_im_s2   <= sat(rnd(eta_im_sum));
			x_re_s2     <= x_re_s1;
			x_im_s2     <= x_im_s1;
			v_re_s2     <= v_re_s1;
			v_im_s2     <= v_im_s1;
			tag_s2      <= tag_s1;

			xr_er_s3    <= x_re_s2 * eta_re_s2;
			xi_ei_s3    <= x_im_s2 * eta_im_s2;
			xr_ei_s3    <= x_re_s2 * eta_im_s2;
			xi_er_s3    <= x_im_s2 * eta_re_s2;
			v_re_s3     <= v_re_s2;
			v_im_s3     <= v_im_s2;
			tag_s3      <= tag_s2;

			result_re_q <= res_re;
			result_im_q <= res_im;
			last_q      <= tag_s3.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_re    = result_re_q;
	assign result_im    = result_im_q;
	assign last_element = last_q;

endmodule

/* hw/rtl/tru_checker.sv */
// port-level checks for the triangular rank-one update core, bound to the top level
module tru_checker #(
	parameter int MAX_DIM    = 64,
	parameter int DATA_WIDTH = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         push,
	input logic                         full,
	input logic [1:0]                   kind,
	input logic                         empty,
	input logic                         pop,
	input logic signed [DATA_WIDTH-1:0] result_re,
	input logic signed [DATA_WIDTH-1:0] result_im,
	input logic                         last_element
);

	localparam int PEND_W = $clog2(MAX_DIM) + 2;

	logic              mat_beat, res_beat;
	logic [PEND_W-1:0] pending_q;

	assign mat_beat = push && !full && (kind == tru_pkg::KIND_MATRIX);
	assign res_beat = pop && !empty;

	// matrix beats accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (mat_beat && !res_beat) begin
			pending_q <= pending_q + PEND_W'(1);
		end else if (res_beat && !mat_beat) begin
			pending_q <= pending_q - PEND_W'(1);
		end
	end

	// no result without a matrix beat behind it
	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pending_q != '0)
		else $error("result shown with no matrix beat outstanding");

	// an idle block never refuses a beat
	a_idle_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == '0 |-> !full)
		else $error("full raised while nothing is in flight");

	// fixed latency through an idle block
	a_idle_latency: assert property (@(posedge clk) disable iff (!arst_n)
		mat_beat && pending_q == '0 |-> ##6 !empty)
		else $error("matrix beat not delivered after six cycles");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result_re) && $stable(result_im)
			&& $stable(last_element))
		else $error("stalled result changed");

endmodule

bind triangular_rank1_update_core tru_checker #(
	.MAX_DIM    (MAX_DIM),
	.DATA_WIDTH (DATA_WIDTH)
) u_tru_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.push         (push),
	.full         (full),
	.kind         (kind),
	.empty        (empty),
	.pop          (pop),
	.result_re    (result_re),
	.result_im    (result_im),
	.last_element (last_element)
);

/* tb/sv/rank1_update_checker.sv */
// predicts each updated matrix element of the rank-one update core and checks the result beats
module rank1_update_checker #(
	parameter int MAX_DIM    = 64,
	parameter int DATA_WIDTH = 16,
	parameter int CFG_W      = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic                              full,
	input  logic [1:0]                        kind,
	input  logic [$clog2(MAX_DIM)-1:0]        index,
	input  logic signed [DATA_WIDTH-1:0]      value_re,
	input  logic signed [DATA_WIDTH-1:0]      value_im,
	input  logic                              empty,
	input  logic                              pop,
	input  logic signed [DATA_WIDTH-1:0]      result_re,
	input  logic signed [DATA_WIDTH-1:0]      result_im,
	input  logic                              last_element,
	input  logic                              cfg_write,
	input  logic [tru_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]                  cfg_data,
	output int                                failures,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     FRAC  = DATA_WIDTH - 4;
	localparam longint Q_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
	localparam longint Q_MIN = -Q_MAX - 1;

	typedef struct {
		logic signed [DATA_WIDTH-1:0] re;
		logic signed [DATA_WIDTH-1:0] im;
		logic                         last;
	} element_t;

	logic signed [DATA_WIDTH-1:0] x_re [MAX_DIM];
	logic signed [DATA_WIDTH-1:0] x_im [MAX_DIM];
	logic signed [DATA_WIDTH-1:0] y_re [MAX_DIM];
	logic signed [DATA_WIDTH-1:0] y_im [MAX_DIM];
	logic signed [DATA_WIDTH-1:0] alpha_re;
	logic signed [DATA_WIDTH-1:0] alpha_im;
	logic                         lower_tri;
	logic                         conj_mode;
	logic [6:0]                   row_cnt;
	logic [6:0]                   col_cnt;
	int unsigned                  row_pos;
	int unsigned                  col_pos;
	element_t                     expected_elems [$];
	element_t                     want;

	// nearest, ties towards plus infinity
	function automatic longint round_q(input longint acc);
		return (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic longint clamp_q(input longint v);
		return (v > Q_MAX) ? Q_MAX : ((v < Q_MIN) ? Q_MIN : v);
	endfunction

	function automatic int unsigned dim_in_use(input logic [6:0] c);
		if (c == 0) return 1;
		if (c > MAX_DIM) return MAX_DIM;
		return c;
	endfunction

	// updated element at the current position, then advance the position
	function automatic element_t update_element(input logic signed [DATA_WIDTH-1:0] a_re,
			input logic signed [DATA_WIDTH-1:0] a_im);
		element_t    e;
		int unsigned m, n, i, j;
		longint      yr, yi, er, ei, xr, xi, rr, ri;
		m  = dim_in_use(row_cnt);
		n  = dim_in_use(col_cnt);
		i  = row_pos % MAX_DIM;
		j  = col_pos % MAX_DIM;
		rr = a_re;
		ri = a_im;
		if (lower_tri ? (i >= j) : (i <= j)) begin
			yr = y_re[j];
			yi = conj_mode ? -longint'(y_im[j]) : longint'(y_im[j]);
			er = clamp_q(round_q(longint'(alpha_re) * yr - longint'(alpha_im) * yi));
			ei = clamp_q(round_q(longint'(alpha_re) * yi + longint'(alpha_im) * yr));
			xr = x_re[i];
			xi = x_im[i];
			rr = clamp_q(longint'(a_re) + round_q(xr * er - xi * ei));
			ri = clamp_q(longint'(a_im) + round_q(xr * ei + xi * er));
			if (conj_mode && i == j) ri = 0;
		end
		e.re   = rr[DATA_WIDTH-1:0];
		e.im   = ri[DATA_WIDTH-1:0];
		e.last = (i + 1 >= m) && (j + 1 >= n);
		i++;
		if (i >= m) begin
			i = 0;
			j++;
			if (j >= n) j = 0;
		end
		row_pos = i;
		col_pos = j;
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_re  = DATA_WIDTH'(1 << FRAC);
			alpha_im  = '0;
			lower_tri = 1'b1;
			conj_mode = 1'b0;
			row_cnt   = 7'(MAX_DIM);
			col_cnt   = 7'(MAX_DIM);
			row_pos   = 0;
			col_pos   = 0;
			expected_elems.delete();
			failures  = 0;
			pending   = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_elems.size() == 0) begin
					failures++;
					$display("%0t: unexpected result beat: expected none, got re %0d im %0d last %0b",
						$time, result_re, result_im, last_element);
				end else begin
					want = expected_elems.pop_front();
					if (result_re !== want.re || result_im !== want.im ||
							last_element !== want.last) begin
						failures++;
						$display("%0t: element mismatch: expected re %0d im %0d last %0b, got re %0d im %0d last %0b",
							$time, want.re, want.im, want.last,
							result_re, result_im, last_element);
					end
				end
			end
			if (push && !full) begin
				case (kind)
					tru_pkg::KIND_LOAD_X: begin
						x_re[index] = value_re;
						x_im[index] = value_im;
					end
					tru_pkg::KIND_LOAD_Y: begin
						y_re[index] = value_re;
						y_im[index] = value_im;
					end
					tru_pkg::KIND_MATRIX:
						expected_elems.push_back(update_element(value_re, value_im));
					default: ;
				endcase
			end
			if (cfg_write) begin
				case (cfg_index)
					tru_pkg::CFG_ALPHA_RE:       alpha_re  = cfg_data[DATA_WIDTH-1:0];
					tru_pkg::CFG_ALPHA_IM:       alpha_im  = cfg_data[DATA_WIDTH-1:0];
					tru_pkg::CFG_LOWER_TRIANGLE: lower_tri = cfg_data[0];
					tru_pkg::CFG_CONJUGATE_MODE: conj_mode = cfg_data[0];
					tru_pkg::CFG_ROW_COUNT:      row_cnt   = cfg_data[6:0];
					tru_pkg::CFG_COL_COUNT:      col_cnt   = cfg_data[6:0];
					default: ;
				endcase
			end
			pending = expected_elems.size();
		end
	end

endmodule

/* tb/sv/triangular_rank1_update_core_tb.sv */
// testbench top for the triangular rank-one update core: stimulus, idling and verdict
module triangular_rank1_update_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM     = 64;
	localparam int DATA_WIDTH  = 16;
	localparam int IDX_W       = $clog2(MAX_DIM);
	localparam int CFG_W       = (DATA_WIDTH > $clog2(MAX_DIM + 1)) ?
	                             DATA_WIDTH : $clog2(MAX_DIM + 1);
	// matrix beat to result ports; SETTLE leaves a little margin beyond it
	localparam int LATENCY     = 6;
	localparam int SETTLE      = LATENCY + 4;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;
	localparam int ITEM_TARGET = 1950;
	localparam int PHASE_ITEMS = 150;

	// the one kind code the package leaves unnamed; the core drops it
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [DATA_WIDTH-1:0] Q_POS = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] Q_NEG = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
	localparam logic [DATA_WIDTH-1:0] Q_ONE = DATA_WIDTH'(1 << (DATA_WIDTH - 4));

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          push         = 1'b0;
	logic                          full;
	logic [1:0]                    kind         = tru_pkg::KIND_LOAD_X;
	logic [IDX_W-1:0]              index        = '0;
	logic signed [DATA_WIDTH-1:0]  value_re     = '0;
	logic signed [DATA_WIDTH-1:0]  value_im     = '0;
	logic                          empty;
	logic                          pop          = 1'b0;
	logic signed [DATA_WIDTH-1:0]  result_re;
	logic signed [DATA_WIDTH-1:0]  result_im;
	logic                          last_element;
	logic                          cfg_write    = 1'b0;
	logic [tru_pkg::CFG_IDX_W-1:0] cfg_index    = tru_pkg::CFG_ALPHA_RE;
	logic [CFG_W-1:0]              cfg_data     = '0;

	int         failures;
	int         pending;
	idle_mode_t idle_mode     = IDLE_NONE;
	int         hold_requests = 0;
	int         holds_done    = 0;
	int         items_sent    = 0;
	// matrix shape in use, as the core will see it after clamping
	int         row_span      = MAX_DIM;
	int         col_span      = MAX_DIM;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	triangular_rank1_update_core #(
		.MAX_DIM   (MAX_DIM),
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.kind        (kind),
		.index       (index),
		.value_re    (value_re),
		.value_im    (value_im),
		.empty       (empty),
		.pop         (pop),
		.result_re   (result_re),
		.result_im   (result_im),
		.last_element(last_element),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// watches both channels and the register port, counts failures
	rank1_update_checker #(
		.MAX_DIM   (MAX_DIM),
		.DATA_WIDTH(DATA_WIDTH),
		.CFG_W     (CFG_W)
	) update_check (.*);

	function automatic int sender_idle_pct();
		case (idle_mode)
			IDLE_SENDER: return 60;
			IDLE_BOTH:   return 33;
			default:     return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct();
		case (idle_mode)
			IDLE_RECEIVER: return 60;
			IDLE_BOTH:     return 33;
			default:       return 0;
		endcase
	endfunction

	// q4.12 value: wide random, an extreme, or something near unity so not all saturates
	function automatic logic [DATA_WIDTH-1:0] rand_q();
		case ($urandom_range(3))
			0: return DATA_WIDTH'($urandom);
			1: begin
				case ($urandom_range(3))
					0:       return Q_POS;
					1:       return Q_NEG;
					2:       return '0;
					default: return '1;
				endcase
			end
			default: return DATA_WIDTH'(int'($urandom_range(8192)) - 4096);
		endcase
	endfunction

	// one beat on the input channel; push stays up afterwards so back-to-back beats
	// need no gap, and the idle loop is where the sender's gaps come from
	task automatic send_item(input logic [1:0] k, input logic [IDX_W-1:0] idx,
			input logic [DATA_WIDTH-1:0] re, input logic [DATA_WIDTH-1:0] im);
		while ($urandom_range(99) < sender_idle_pct()) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push     <= 1'b1;
		kind     <= k;
		index    <= idx;
		value_re <= re;
		value_im <= im;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
		// dropped beats do not count towards the run length
		if (k != KIND_UNUSED) items_sent++;
	endtask

	// stray beats: the unused kind, or a reload of some random store entry
	task automatic send_noise();
		case ($urandom_range(2))
			0:       send_item(KIND_UNUSED, IDX_W'($urandom), rand_q(), rand_q());
			1:       send_item(tru_pkg::KIND_LOAD_X, IDX_W'($urandom), rand_q(), rand_q());
			default: send_item(tru_pkg::KIND_LOAD_Y, IDX_W'($urandom), rand_q(), rand_q());
		endcase
	endtask

	// register write without lowering the strobe, so writes go back to back
	task automatic put_reg(input tru_pkg::cfg_reg_t r, input logic [CFG_W-1:0] d);
		cfg_write <= 1'b1;
		cfg_index <= r;
		cfg_data  <= d;
		@(negedge clk);
	endtask

	task automatic apply_settings(input logic [DATA_WIDTH-1:0] a_re,
			input logic [DATA_WIDTH-1:0] a_im, input logic lower, input logic conj,
			input int rows, input int cols);
		put_reg(tru_pkg::CFG_ALPHA_RE, CFG_W'(a_re));
		put_reg(tru_pkg::CFG_ALPHA_IM, CFG_W'(a_im));
		put_reg(tru_pkg::CFG_LOWER_TRIANGLE, CFG_W'(lower));
		put_reg(tru_pkg::CFG_CONJUGATE_MODE, CFG_W'(conj));
		put_reg(tru_pkg::CFG_ROW_COUNT, CFG_W'(rows));
		put_reg(tru_pkg::CFG_COL_COUNT, CFG_W'(cols));
		cfg_write <= 1'b0;
		// a count of zero acts as one, anything past the store depth as the depth
		row_span = (rows == 0) ? 1 : ((rows > MAX_DIM) ? MAX_DIM : rows);
		col_span = (cols == 0) ? 1 : ((cols > MAX_DIM) ? MAX_DIM : cols);
	endtask

	// sender holds off until every result is back, then lets loads still in
	// flight reach the stores before anything touches the registers
	task automatic wait_drained();
		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// fresh x and y vectors for the shape in use, then the matrix in column-major
	// order, cut short when the phase has had its share of beats
	task automatic run_matrix(input int budget_end);
		int k;
		for (k = 0; k < row_span; k++) begin
			if ($urandom_range(7) == 0) send_noise();
			send_item(tru_pkg::KIND_LOAD_X, IDX_W'(k), rand_q(), rand_q());
		end
		for (k = 0; k < col_span; k++) begin
			if ($urandom_range(7) == 0) send_noise();
			send_item(tru_pkg::KIND_LOAD_Y, IDX_W'(k), rand_q(), rand_q());
		end
		for (k = 0; k < row_span * col_span && items_sent < budget_end; k++) begin
			if ($urandom_range(15) == 0) send_noise();
			send_item(tru_pkg::KIND_MATRIX, IDX_W'($urandom), rand_q(), rand_q());
		end
	endtask

	// result side: random stalls per phase, plus a long hold-off when asked,
	// counted here so the sender keeps offering beats meanwhile
	initial begin
		int k;
		forever begin
			@(negedge clk);
			if (holds_done != hold_requests) begin
				pop <= 1'b0;
				for (k = 1; k < HOLD_CYCLES; k++) @(negedge clk);
				holds_done++;
			end else begin
				pop <= ($urandom_range(99) >= receiver_stall_pct());
			end
		end
	end

	// watchdog: too long without a beat on either channel means the core is stuck
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) quiet = 0;
			else quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int                    ph;
		int                    k;
		int                    phase_end;
		int                    rows, cols;
		logic                  lower, conj;
		logic [DATA_WIDTH-1:0] a_re, a_im;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: 2x2, lower and conjugated, alpha at both extremes; covers the
		// field extremes, the dropped kind, the top store index, the diagonal
		// imaginary clear, the pass-through corner and the last-element flag
		apply_settings(Q_POS, Q_NEG, 1'b1, 1'b1, 2, 2);
		send_item(tru_pkg::KIND_LOAD_X, IDX_W'(0), Q_POS, Q_NEG);
		send_item(tru_pkg::KIND_LOAD_X, IDX_W'(1), Q_NEG, Q_POS);
		send_item(tru_pkg::KIND_LOAD_Y, IDX_W'(0), Q_NEG, Q_NEG);
		send_item(tru_pkg::KIND_LOAD_Y, IDX_W'(1), Q_POS, DATA_WIDTH'(1));
		send_item(KIND_UNUSED, '1, Q_POS, Q_NEG);
		send_item(tru_pkg::KIND_LOAD_X, '1, '1, '0);
		send_item(tru_pkg::KIND_LOAD_Y, '1, '0, '1);
		send_item(tru_pkg::KIND_MATRIX, '0, Q_POS, Q_POS);
		send_item(tru_pkg::KIND_MATRIX, '1, Q_NEG, Q_NEG);
		send_item(tru_pkg::KIND_MATRIX, '0, '0, '0);
		send_item(tru_pkg::KIND_MATRIX, '1, '1, DATA_WIDTH'(1));
		wait_drained();

		// random phases; idling cycles through none, sender, receiver, both
		ph = 0;
		while (items_sent < ITEM_TARGET) begin
			idle_mode = idle_mode_t'(ph % 4);
			a_re  = rand_q();
			a_im  = rand_q();
			lower = $urandom_range(1);
			conj  = $urandom_range(1);
			rows  = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(1, 8);
			cols  = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(1, 8);
			case (ph)
				0: begin
					// reset-like settings on an 8x8
					a_re = Q_ONE; a_im = '0; lower = 1'b1; conj = 1'b0; rows = 8; cols = 8;
				end
				1: begin
					// tall single column, upper triangle
					a_re = Q_POS; a_im = Q_NEG; lower = 1'b0; conj = 1'b1; rows = 64; cols = 1;
				end
				2: begin
					// wide single row
					a_re = Q_NEG; a_im = Q_POS; lower = 1'b1; conj = 1'b1; rows = 1; cols = 64;
				end
				3: begin
					// counts outside the legal range, zero alpha
					a_re = '0; a_im = '0; lower = 1'b0; conj = 1'b0; rows = 0; cols = 127;
				end
				4: begin
					rows = 100; cols = 2;
				end
				default: ;
			endcase
			apply_settings(a_re, a_im, lower, conj, rows, cols);

			// every store entry gets a value early, so later beats may land
			// anywhere, including counters left beyond a shrunk shape
			if (ph == 0) begin
				for (k = 0; k < MAX_DIM; k++)
					send_item(tru_pkg::KIND_LOAD_X, IDX_W'(k), rand_q(), rand_q());
				for (k = 0; k < MAX_DIM; k++)
					send_item(tru_pkg::KIND_LOAD_Y, IDX_W'(k), rand_q(), rand_q());
			end

			// long result hold-off so the internal queue fills and full rises
			if (ph == 4 || ph == 8) hold_requests++;

			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) run_matrix(phase_end);
			wait_drained();
			ph++;
		end

		if (failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/tru_pkg.sv
hw/rtl/tru_front.sv
hw/rtl/tru_queue.sv
hw/rtl/tru_back.sv
hw/rtl/triangular_rank1_update_core.sv
hw/rtl/tru_checker.sv
tb/sv/rank1_update_checker.sv
tb/sv/triangular_rank1_update_core_tb.sv
